// ===== src/mos6502_instruction_execute_top_macros.svh =====
// Assertion macros for the 6502 instruction executor.
// Used by the top level only; no other dependencies.
`ifndef MOS6502_INSTRUCTION_EXECUTE_TOP_MACROS_SVH
`define MOS6502_INSTRUCTION_EXECUTE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: label");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed: label");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== src/m65x_pkg.sv =====
// Shared types, codes and decode table for the 6502 instruction executor.
// No dependencies.
`timescale 1ns / 1ps
package m65x_pkg;
  localparam int MEM_ADDR_BITS_DEF = 16;

  localparam logic [1:0] KIND_EXEC  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  typedef enum logic [3:0] {
    M_IMP, M_ACC, M_IMM, M_ZP, M_ZPX, M_ZPY, M_REL, M_ABS, M_ABX, M_ABY, M_IND, M_IZX, M_IZY
  } mode_t;

  typedef enum logic [5:0] {
    OP_NONE, OP_ADC, OP_AND, OP_ASL, OP_BCC, OP_BCS, OP_BEQ, OP_BIT, OP_BMI, OP_BNE,
    OP_BPL, OP_BRK, OP_BVC, OP_BVS, OP_CLC, OP_CLD, OP_CLI, OP_CLV, OP_CMP, OP_CPX,
    OP_CPY, OP_DEC, OP_DEX, OP_DEY, OP_EOR, OP_INC, OP_INX, OP_INY, OP_JMP, OP_JSR,
    OP_LDA, OP_LDX, OP_LDY, OP_LSR, OP_NOP, OP_ORA, OP_PHA, OP_PHP, OP_PLA, OP_PLP,
    OP_ROL, OP_ROR, OP_RTI, OP_RTS, OP_SBC, OP_SEC, OP_SED, OP_SEI, OP_STA, OP_STX,
    OP_STY, OP_TAX, OP_TAY, OP_TSX, OP_TXA, OP_TXS, OP_TYA
  } op_t;

  typedef struct packed {
    op_t        op;
    mode_t      mode;
    logic [3:0] cyc;
  } decode_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PTR0, S_PTR1, S_OPRD, S_EXEC, S_WB, S_PUSH, S_POP, S_VEC0, S_VEC1, S_DONE
  } state_t;

  // memory request from the sequencer
  typedef struct packed {
    logic        en;
    logic        we;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } mem_req_t;

  function automatic decode_t dcd(input op_t o, input mode_t m, input int c);
    decode_t d;
    d.op = o;
    d.mode = m;
    d.cyc = c[3:0];
    return d;
  endfunction

  function automatic decode_t decode(input logic [7:0] opc);
    decode_t d;
    d = dcd(OP_NONE, M_IMP, 0);
    unique case (opc)
      8'h69: d = dcd(OP_ADC, M_IMM, 2); 8'h65: d = dcd(OP_ADC, M_ZP, 3);
      8'h75: d = dcd(OP_ADC, M_ZPX, 4); 8'h6D: d = dcd(OP_ADC, M_ABS, 4);
      8'h7D: d = dcd(OP_ADC, M_ABX, 4); 8'h79: d = dcd(OP_ADC, M_ABY, 4);
      8'h61: d = dcd(OP_ADC, M_IZX, 6); 8'h71: d = dcd(OP_ADC, M_IZY, 5);
      8'h29: d = dcd(OP_AND, M_IMM, 2); 8'h25: d = dcd(OP_AND, M_ZP, 3);
      8'h35: d = dcd(OP_AND, M_ZPX, 4); 8'h2D: d = dcd(OP_AND, M_ABS, 4);
      8'h3D: d = dcd(OP_AND, M_ABX, 4); 8'h39: d = dcd(OP_AND, M_ABY, 4);
      8'h21: d = dcd(OP_AND, M_IZX, 6); 8'h31: d = dcd(OP_AND, M_IZY, 5);
      8'h0A: d = dcd(OP_ASL, M_ACC, 2); 8'h06: d = dcd(OP_ASL, M_ZP, 5);
      8'h16: d = dcd(OP_ASL, M_ZPX, 6); 8'h0E: d = dcd(OP_ASL, M_ABS, 6);
      8'h1E: d = dcd(OP_ASL, M_ABX, 7);
      8'h90: d = dcd(OP_BCC, M_REL, 2); 8'hB0: d = dcd(OP_BCS, M_REL, 2);
      8'hF0: d = dcd(OP_BEQ, M_REL, 2); 8'h30: d = dcd(OP_BMI, M_REL, 2);
      8'hD0: d = dcd(OP_BNE, M_REL, 2); 8'h10: d = dcd(OP_BPL, M_REL, 2);
      8'h50: d = dcd(OP_BVC, M_REL, 2); 8'h70: d = dcd(OP_BVS, M_REL, 2);
      8'h24: d = dcd(OP_BIT, M_ZP, 3);  8'h2C: d = dcd(OP_BIT, M_ABS, 4);
      8'h00: d = dcd(OP_BRK, M_IMP, 7);
      8'h18: d = dcd(OP_CLC, M_IMP, 2); 8'hD8: d = dcd(OP_CLD, M_IMP, 2);
      8'h58: d = dcd(OP_CLI, M_IMP, 2); 8'hB8: d = dcd(OP_CLV, M_IMP, 2);
      8'hC9: d = dcd(OP_CMP, M_IMM, 2); 8'hC5: d = dcd(OP_CMP, M_ZP, 3);
      8'hD5: d = dcd(OP_CMP, M_ZPX, 4); 8'hCD: d = dcd(OP_CMP, M_ABS, 4);
      8'hDD: d = dcd(OP_CMP, M_ABX, 4); 8'hD9: d = dcd(OP_CMP, M_ABY, 4);
      8'hC1: d = dcd(OP_CMP, M_IZX, 6); 8'hD1: d = dcd(OP_CMP, M_IZY, 5);
      8'hE0: d = dcd(OP_CPX, M_IMM, 2); 8'hE4: d = dcd(OP_CPX, M_ZP, 3);
      8'hEC: d = dcd(OP_CPX, M_ABS, 4);
      8'hC0: d = dcd(OP_CPY, M_IMM, 2); 8'hC4: d = dcd(OP_CPY, M_ZP, 3);
      8'hCC: d = dcd(OP_CPY, M_ABS, 4);
      8'hC6: d = dcd(OP_DEC, M_ZP, 5);  8'hD6: d = dcd(OP_DEC, M_ZPX, 6);
      8'hCE: d = dcd(OP_DEC, M_ABS, 6); 8'hDE: d = dcd(OP_DEC, M_ABX, 7);
      8'hCA: d = dcd(OP_DEX, M_IMP, 2); 8'h88: d = dcd(OP_DEY, M_IMP, 2);
      8'h49: d = dcd(OP_EOR, M_IMM, 2); 8'h45: d = dcd(OP_EOR, M_ZP, 3);
      8'h55: d = dcd(OP_EOR, M_ZPX, 4); 8'h4D: d = dcd(OP_EOR, M_ABS, 4);
      8'h5D: d = dcd(OP_EOR, M_ABX, 4); 8'h59: d = dcd(OP_EOR, M_ABY, 4);
      8'h41: d = dcd(OP_EOR, M_IZX, 6); 8'h51: d = dcd(OP_EOR, M_IZY, 5);
      8'hE6: d = dcd(OP_INC, M_ZP, 5);  8'hF6: d = dcd(OP_INC, M_ZPX, 6);
      8'hEE: d = dcd(OP_INC, M_ABS, 6); 8'hFE: d = dcd(OP_INC, M_ABX, 7);
      8'hE8: d = dcd(OP_INX, M_IMP, 2); 8'hC8: d = dcd(OP_INY, M_IMP, 2);
      8'h4C: d = dcd(OP_JMP, M_ABS, 3); 8'h6C: d = dcd(OP_JMP, M_IND, 5);
      8'h20: d = dcd(OP_JSR, M_ABS, 6);
      8'hA9: d = dcd(OP_LDA, M_IMM, 2); 8'hA5: d = dcd(OP_LDA, M_ZP, 3);
      8'hB5: d = dcd(OP_LDA, M_ZPX, 4); 8'hAD: d = dcd(OP_LDA, M_ABS, 4);
      8'hBD: d = dcd(OP_LDA, M_ABX, 4); 8'hB9: d = dcd(OP_LDA, M_ABY, 4);
      8'hA1: d = dcd(OP_LDA, M_IZX, 6); 8'hB1: d = dcd(OP_LDA, M_IZY, 5);
      8'hA2: d = dcd(OP_LDX, M_IMM, 2); 8'hA6: d = dcd(OP_LDX, M_ZP, 3);
      8'hB6: d = dcd(OP_LDX, M_ZPY, 4); 8'hAE: d = dcd(OP_LDX, M_ABS, 4);
      8'hBE: d = dcd(OP_LDX, M_ABY, 4);
      8'hA0: d = dcd(OP_LDY, M_IMM, 2); 8'hA4: d = dcd(OP_LDY, M_ZP, 3);
      8'hB4: d = dcd(OP_LDY, M_ZPX, 4); 8'hAC: d = dcd(OP_LDY, M_ABS, 4);
      8'hBC: d = dcd(OP_LDY, M_ABX, 4);
      8'h4A: d = dcd(OP_LSR, M_ACC, 2); 8'h46: d = dcd(OP_LSR, M_ZP, 5);
      8'h56: d = dcd(OP_LSR, M_ZPX, 6); 8'h4E: d = dcd(OP_LSR, M_ABS, 6);
      8'h5E: d = dcd(OP_LSR, M_ABX, 7);
      8'hEA: d = dcd(OP_NOP, M_IMP, 2);
      8'h09: d = dcd(OP_ORA, M_IMM, 2); 8'h05: d = dcd(OP_ORA, M_ZP, 3);
      8'h15: d = dcd(OP_ORA, M_ZPX, 4); 8'h0D: d = dcd(OP_ORA, M_ABS, 4);
      8'h1D: d = dcd(OP_ORA, M_ABX, 4); 8'h19: d = dcd(OP_ORA, M_ABY, 4);
      8'h01: d = dcd(OP_ORA, M_IZX, 6); 8'h11: d = dcd(OP_ORA, M_IZY, 5);
      8'h48: d = dcd(OP_PHA, M_IMP, 3); 8'h08: d = dcd(OP_PHP, M_IMP, 3);
      8'h68: d = dcd(OP_PLA, M_IMP, 4); 8'h28: d = dcd(OP_PLP, M_IMP, 4);
      8'h2A: d = dcd(OP_ROL, M_ACC, 2); 8'h26: d = dcd(OP_ROL, M_ZP, 5);
      8'h36: d = dcd(OP_ROL, M_ZPX, 6); 8'h2E: d = dcd(OP_ROL, M_ABS, 6);
      8'h3E: d = dcd(OP_ROL, M_ABX, 7);
      8'h6A: d = dcd(OP_ROR, M_ACC, 2); 8'h66: d = dcd(OP_ROR, M_ZP, 5);
      8'h76: d = dcd(OP_ROR, M_ZPX, 6); 8'h6E: d = dcd(OP_ROR, M_ABS, 6);
      8'h7E: d = dcd(OP_ROR, M_ABX, 7);
      8'h40: d = dcd(OP_RTI, M_IMP, 6); 8'h60: d = dcd(OP_RTS, M_IMP, 6);
      8'hE9: d = dcd(OP_SBC, M_IMM, 2); 8'hE5: d = dcd(OP_SBC, M_ZP, 3);
      8'hF5: d = dcd(OP_SBC, M_ZPX, 4); 8'hED: d = dcd(OP_SBC, M_ABS, 4);
      8'hFD: d = dcd(OP_SBC, M_ABX, 4); 8'hF9: d = dcd(OP_SBC, M_ABY, 4);
      8'hE1: d = dcd(OP_SBC, M_IZX, 6); 8'hF1: d = dcd(OP_SBC, M_IZY, 5);
      8'h38: d = dcd(OP_SEC, M_IMP, 2); 8'hF8: d = dcd(OP_SED, M_IMP, 2);
      8'h78: d = dcd(OP_SEI, M_IMP, 2);
      8'h85: d = dcd(OP_STA, M_ZP, 3);  8'h95: d = dcd(OP_STA, M_ZPX, 4);
      8'h8D: d = dcd(OP_STA, M_ABS, 4); 8'h9D: d = dcd(OP_STA, M_ABX, 5);
      8'h99: d = dcd(OP_STA, M_ABY, 5); 8'h81: d = dcd(OP_STA, M_IZX, 6);
      8'h91: d = dcd(OP_STA, M_IZY, 6);
      8'h86: d = dcd(OP_STX, M_ZP, 3);  8'h96: d = dcd(OP_STX, M_ZPY, 4);
      8'h8E: d = dcd(OP_STX, M_ABS, 4);
      8'h84: d = dcd(OP_STY, M_ZP, 3);  8'h94: d = dcd(OP_STY, M_ZPX, 4);
      8'h8C: d = dcd(OP_STY, M_ABS, 4);
      8'hAA: d = dcd(OP_TAX, M_IMP, 2); 8'hA8: d = dcd(OP_TAY, M_IMP, 2);
      8'hBA: d = dcd(OP_TSX, M_IMP, 2); 8'h8A: d = dcd(OP_TXA, M_IMP, 2);
      8'h9A: d = dcd(OP_TXS, M_IMP, 2); 8'h98: d = dcd(OP_TYA, M_IMP, 2);
      default: d = dcd(OP_NONE, M_IMP, 0);
    endcase
    return d;
  endfunction

  function automatic logic [1:0] mode_len(input mode_t m);
    unique case (m)
      M_IMP, M_ACC: return 2'd1;
      M_ABS, M_ABX, M_ABY, M_IND: return 2'd3;
      default: return 2'd2;
    endcase
  endfunction
endpackage

// ===== src/m65x_mem.sv =====
// Byte-wide single-port data memory with a registered read.
// Depends on m65x_pkg for the request struct.
`timescale 1ns / 1ps
module m65x_mem
  import m65x_pkg::*;
#(
  parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
) (
  input  logic     clk,
  input  mem_req_t req,
  output logic [7:0] rdata
);
  logic [7:0] mem [0:(1 << MEM_ADDR_BITS) - 1];
  logic [MEM_ADDR_BITS-1:0] a;

  assign a = req.addr[MEM_ADDR_BITS-1:0];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[a] <= req.wdata;
      end
      rdata <= mem[a];
    end
  end
endmodule

// ===== src/m65x_seq.sv =====
// Instruction sequencer: registers, address generation, ALU and memory steps.
// Depends on m65x_pkg; drives m65x_mem through a request struct.
`timescale 1ns / 1ps
module m65x_seq
  import m65x_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [1:0]  kind,
  input  logic [7:0]  opcode,
  input  logic [7:0]  op_lo,
  input  logic [7:0]  op_hi,
  input  logic [7:0]  wdata_in,
  input  logic [7:0]  mem_rdata,
  output mem_req_t    req,
  output logic        done,
  output logic [7:0]  a_o,
  output logic [7:0]  x_o,
  output logic [7:0]  y_o,
  output logic [7:0]  p_o,
  output logic [7:0]  s_o,
  output logic [15:0] pc_o,
  output logic [7:0]  rd_o,
  output logic [3:0]  cyc_o,
  output logic        bad_o
);
  state_t state_r, state_nxt;
  logic [7:0] a_r, a_nxt, x_r, x_nxt, y_r, y_nxt, p_r, p_nxt, s_r, s_nxt;
  logic [15:0] pc_r, pc_nxt, ea_r, ea_nxt;
  logic [7:0] lo_r, lo_nxt, hi_r, hi_nxt, m_r, m_nxt, rd_r, rd_nxt;
  logic [3:0] cyc_r, cyc_nxt;
  logic bad_r, bad_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  decode_t d_r, d_nxt;
  logic [7:0] wb_r, wb_nxt;
  logic [15:0] ptr_r, ptr_nxt;

  logic [8:0] sum;
  logic [7:0] addend, res;
  logic [15:0] tgt;
  logic take;
  decode_t dec_in;
  logic [15:0] pc_inc;

  assign dec_in = decode(opcode);
  assign pc_inc = pc_r + 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      a_r <= 8'h00; x_r <= 8'h00; y_r <= 8'h00;
      p_r <= 8'h24; s_r <= 8'hFD; pc_r <= 16'h0000;
    end else begin
      state_r <= state_nxt;
      a_r <= a_nxt; x_r <= x_nxt; y_r <= y_nxt;
      p_r <= p_nxt; s_r <= s_nxt; pc_r <= pc_nxt;
    end
    ea_r <= ea_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt; m_r <= m_nxt;
    rd_r <= rd_nxt; cyc_r <= cyc_nxt; bad_r <= bad_nxt; cnt_r <= cnt_nxt;
    d_r <= d_nxt; wb_r <= wb_nxt; ptr_r <= ptr_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    a_nxt = a_r; x_nxt = x_r; y_nxt = y_r; p_nxt = p_r; s_nxt = s_r; pc_nxt = pc_r;
    ea_nxt = ea_r; lo_nxt = lo_r; hi_nxt = hi_r; m_nxt = m_r; rd_nxt = rd_r;
    cyc_nxt = cyc_r; bad_nxt = bad_r; cnt_nxt = cnt_r; d_nxt = d_r; wb_nxt = wb_r;
    ptr_nxt = ptr_r;
    req = '0;
    done = 1'b0;
    addend = (d_r.op == OP_SBC) ? ~m_r : m_r;
    sum = {1'b0, a_r} + {1'b0, addend} + {8'h00, p_r[0]};
    res = 8'h00;
    take = 1'b0;
    tgt = pc_r + {{8{lo_r[7]}}, lo_r};
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          lo_nxt = op_lo; hi_nxt = op_hi;
          rd_nxt = 8'h00; cyc_nxt = 4'd0; bad_nxt = 1'b0;
          d_nxt = dec_in;
          unique case (kind)
            KIND_WRITE: begin
              req = '{en: 1'b1, we: 1'b1, addr: {op_hi, op_lo}, wdata: wdata_in};
              state_nxt = S_DONE;
            end
            KIND_READ: begin
              req = '{en: 1'b1, we: 1'b0, addr: {op_hi, op_lo}, wdata: 8'h00};
              state_nxt = S_OPRD;
              d_nxt = dcd(OP_NONE, M_IMP, 0);
            end
            KIND_EXEC: begin
              if (dec_in.op == OP_NONE) begin
                bad_nxt = 1'b1;
                state_nxt = S_DONE;
              end else begin
                cyc_nxt = dec_in.cyc;
                pc_nxt = pc_r + {14'd0, mode_len(dec_in.mode)};
                cnt_nxt = 2'd0;
                unique case (dec_in.mode)
                  M_ZP:  ea_nxt = {8'h00, op_lo};
                  M_ZPX: ea_nxt = {8'h00, op_lo + x_r};
                  M_ZPY: ea_nxt = {8'h00, op_lo + y_r};
                  M_ABS: ea_nxt = {op_hi, op_lo};
                  M_ABX: ea_nxt = {op_hi, op_lo} + {8'h00, x_r};
                  M_ABY: ea_nxt = {op_hi, op_lo} + {8'h00, y_r};
                  M_IND: ptr_nxt = {op_hi, op_lo};
                  M_IZX: ptr_nxt = {8'h00, op_lo + x_r};
                  M_IZY: ptr_nxt = {8'h00, op_lo};
                  default: ea_nxt = ea_r;
                endcase
                unique case (dec_in.mode)
                  M_IND, M_IZX, M_IZY: state_nxt = S_PTR0;
                  M_IMM, M_REL: begin m_nxt = op_lo; state_nxt = S_EXEC; end
                  M_ACC: begin m_nxt = a_r; state_nxt = S_EXEC; end
                  M_IMP: state_nxt = S_EXEC;
                  default: state_nxt = S_OPRD;
                endcase
                // addresses for direct operand fetch are applied in S_OPRD
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_PTR0: begin
        req = '{en: 1'b1, we: 1'b0, addr: ptr_r, wdata: 8'h00};
        state_nxt = S_PTR1;
      end
      S_PTR1: begin
        // low pointer byte arrives; fetch high byte within the same page
        ea_nxt[7:0] = mem_rdata;
        req = '{en: 1'b1, we: 1'b0, addr: {ptr_r[15:8], ptr_r[7:0] + 8'd1}, wdata: 8'h00};
        cnt_nxt = 2'd1;
        state_nxt = S_OPRD;
      end
      S_OPRD: begin
        if (d_r.op == OP_NONE) begin
          // direct memory read: data returns this cycle
          rd_nxt = mem_rdata;
          state_nxt = S_DONE;
        end else if (cnt_r == 2'd1) begin
          ea_nxt = {mem_rdata, ea_r[7:0]};
          if (d_r.mode == M_IZY) ea_nxt = {mem_rdata, ea_r[7:0]} + {8'h00, y_r};
          cnt_nxt = 2'd0;
          if (d_r.mode == M_IND) begin
            pc_nxt = {mem_rdata, ea_r[7:0]};
            state_nxt = S_DONE;
          end
        end else if (d_r.op == OP_STA || d_r.op == OP_STX || d_r.op == OP_STY ||
                     d_r.op == OP_JMP || d_r.op == OP_JSR) begin
          state_nxt = S_EXEC;
        end else begin
          req = '{en: 1'b1, we: 1'b0, addr: ea_r, wdata: 8'h00};
          cnt_nxt = 2'd2;
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        // operand byte captured, then execute
        m_nxt = mem_rdata;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        unique case (d_r.op)
          OP_ADC, OP_SBC: begin
            a_nxt = sum[7:0];
            p_nxt[6] = (~(a_r[7] ^ addend[7])) & (a_r[7] ^ sum[7]);
            p_nxt[0] = sum[8];
            p_nxt[1] = sum[7:0] == 8'h00; p_nxt[7] = sum[7];
          end
          OP_AND, OP_ORA, OP_EOR, OP_LDA: begin
            unique case (d_r.op)
              OP_AND: res = a_r & m_r;
              OP_ORA: res = a_r | m_r;
              OP_EOR: res = a_r ^ m_r;
              default: res = m_r;
            endcase
            a_nxt = res; p_nxt[1] = res == 8'h00; p_nxt[7] = res[7];
          end
          OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_INC, OP_DEC: begin
            unique case (d_r.op)
              OP_ASL: begin res = {m_r[6:0], 1'b0}; p_nxt[0] = m_r[7]; end
              OP_LSR: begin res = {1'b0, m_r[7:1]}; p_nxt[0] = m_r[0]; end
              OP_ROL: begin res = {m_r[6:0], p_r[0]}; p_nxt[0] = m_r[7]; end
              OP_ROR: begin res = {p_r[0], m_r[7:1]}; p_nxt[0] = m_r[0]; end
              OP_INC: res = m_r + 8'd1;
              default: res = m_r - 8'd1;
            endcase
            p_nxt[1] = res == 8'h00; p_nxt[7] = res[7];
            if (d_r.mode == M_ACC) a_nxt = res;
            else req = '{en: 1'b1, we: 1'b1, addr: ea_r, wdata: res};
          end
          OP_BIT: begin
            p_nxt[1] = (a_r & m_r) == 8'h00; p_nxt[6] = m_r[6]; p_nxt[7] = m_r[7];
          end
          OP_BCC, OP_BCS, OP_BNE, OP_BEQ, OP_BPL, OP_BMI, OP_BVC, OP_BVS: begin
            unique case (d_r.op)
              OP_BCC: take = !p_r[0];
              OP_BCS: take = p_r[0];
              OP_BNE: take = !p_r[1];
              OP_BEQ: take = p_r[1];
              OP_BPL: take = !p_r[7];
              OP_BMI: take = p_r[7];
              OP_BVC: take = !p_r[6];
              default: take = p_r[6];
            endcase
            if (take) begin
              pc_nxt = tgt;
              cyc_nxt = cyc_r + ((tgt[15:8] != pc_r[15:8]) ? 4'd2 : 4'd1);
            end
          end
          OP_CLC: p_nxt[0] = 1'b0;
          OP_CLD: p_nxt[3] = 1'b0;
          OP_CLI: p_nxt[2] = 1'b0;
          OP_CLV: p_nxt[6] = 1'b0;
          OP_SEC: p_nxt[0] = 1'b1;
          OP_SED: p_nxt[3] = 1'b1;
          OP_SEI: p_nxt[2] = 1'b1;
          OP_CMP, OP_CPX, OP_CPY: begin
            unique case (d_r.op)
              OP_CMP: res = a_r;
              OP_CPX: res = x_r;
              default: res = y_r;
            endcase
            p_nxt[0] = res >= m_r;
            res = res - m_r;
            p_nxt[1] = res == 8'h00; p_nxt[7] = res[7];
          end
          OP_DEX: begin
            res = x_r - 8'd1; x_nxt = res; p_nxt[1] = res == 8'h00; p_nxt[7] = res[7];
          end
          OP_DEY: begin
            res = y_r - 8'd1; y_nxt = res; p_nxt[1] = res == 8'h00; p_nxt[7] = res[7];
          end
          OP_INX: begin
            res = x_r + 8'd1; x_nxt = res; p_nxt[1] = res == 8'h00; p_nxt[7] = res[7];
          end
          OP_INY: begin
            res = y_r + 8'd1; y_nxt = res; p_nxt[1] = res == 8'h00; p_nxt[7] = res[7];
          end
          OP_LDX: begin x_nxt = m_r; p_nxt[1] = m_r == 8'h00; p_nxt[7] = m_r[7]; end
          OP_LDY: begin y_nxt = m_r; p_nxt[1] = m_r == 8'h00; p_nxt[7] = m_r[7]; end
          OP_STA: req = '{en: 1'b1, we: 1'b1, addr: ea_r, wdata: a_r};
          OP_STX: req = '{en: 1'b1, we: 1'b1, addr: ea_r, wdata: x_r};
          OP_STY: req = '{en: 1'b1, we: 1'b1, addr: ea_r, wdata: y_r};
          OP_JMP: pc_nxt = ea_r;
          OP_TAX: begin x_nxt = a_r; p_nxt[1] = a_r == 8'h00; p_nxt[7] = a_r[7]; end
          OP_TAY: begin y_nxt = a_r; p_nxt[1] = a_r == 8'h00; p_nxt[7] = a_r[7]; end
          OP_TSX: begin x_nxt = s_r; p_nxt[1] = s_r == 8'h00; p_nxt[7] = s_r[7]; end
          OP_TXA: begin a_nxt = x_r; p_nxt[1] = x_r == 8'h00; p_nxt[7] = x_r[7]; end
          OP_TYA: begin a_nxt = y_r; p_nxt[1] = y_r == 8'h00; p_nxt[7] = y_r[7]; end
          OP_TXS: s_nxt = x_r;
          OP_JSR, OP_BRK, OP_PHA, OP_PHP: begin
            cnt_nxt = 2'd0;
            state_nxt = S_PUSH;
          end
          OP_PLA, OP_PLP, OP_RTS, OP_RTI: begin
            cnt_nxt = 2'd0;
            req = '{en: 1'b1, we: 1'b0, addr: {8'h01, s_r + 8'd1}, wdata: 8'h00};
            s_nxt = s_r + 8'd1;
            state_nxt = S_POP;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_PUSH: begin
        // pushes in order; wb_r unused here
        unique case (d_r.op)
          OP_PHA: wb_nxt = a_r;
          OP_PHP: wb_nxt = p_r | 8'h30;
          OP_JSR: wb_nxt = (cnt_r == 2'd0) ? pc_r[15:8] - {7'd0, pc_r[7:0] == 8'h00}
                                            : pc_r[7:0] - 8'd1;
          default: wb_nxt = (cnt_r == 2'd0) ? pc_inc[15:8] :
                            (cnt_r == 2'd1) ? pc_inc[7:0] : p_r | 8'h30;
        endcase
        req = '{en: 1'b1, we: 1'b1, addr: {8'h01, s_r}, wdata: wb_nxt};
        s_nxt = s_r - 8'd1;
        cnt_nxt = cnt_r + 2'd1;
        if ((d_r.op == OP_PHA) || (d_r.op == OP_PHP)) begin
          state_nxt = S_DONE;
        end else if (d_r.op == OP_JSR && cnt_r == 2'd1) begin
          pc_nxt = ea_r;
          state_nxt = S_DONE;
        end else if (d_r.op == OP_BRK && cnt_r == 2'd2) begin
          p_nxt[2] = 1'b1;
          state_nxt = S_VEC0;
        end
      end
      S_POP: begin
        // previous pop data arrives; issue next pop if one remains
        cnt_nxt = cnt_r + 2'd1;
        state_nxt = S_DONE;
        unique case (d_r.op)
          OP_PLA: begin
            a_nxt = mem_rdata; p_nxt[1] = mem_rdata == 8'h00; p_nxt[7] = mem_rdata[7];
          end
          OP_PLP: p_nxt = (mem_rdata & 8'hEF) | 8'h20;
          OP_RTS: begin
            if (cnt_r == 2'd0) begin
              wb_nxt = mem_rdata; state_nxt = S_POP;
            end else begin
              pc_nxt = {mem_rdata, wb_r} + 16'd1;
            end
          end
          default: begin
            if (cnt_r == 2'd0) begin
              p_nxt = (mem_rdata & 8'hEF) | 8'h20; state_nxt = S_POP;
            end else if (cnt_r == 2'd1) begin
              wb_nxt = mem_rdata; state_nxt = S_POP;
            end else begin
              pc_nxt = {mem_rdata, wb_r};
            end
          end
        endcase
        if (state_nxt == S_POP) begin
          req = '{en: 1'b1, we: 1'b0, addr: {8'h01, s_r + 8'd1}, wdata: 8'h00};
          s_nxt = s_r + 8'd1;
        end
      end
      S_VEC0: begin
        req = '{en: 1'b1, we: 1'b0, addr: 16'hFFFE, wdata: 8'h00};
        state_nxt = S_VEC1;
      end
      S_VEC1: begin
        wb_nxt = mem_rdata;
        req = '{en: 1'b1, we: 1'b0, addr: 16'hFFFF, wdata: 8'h00};
        ptr_nxt = 16'h0000;
        d_nxt.mode = M_IND;
        ea_nxt = {8'h00, mem_rdata};
        cnt_nxt = 2'd1;
        state_nxt = S_OPRD;
      end
      S_DONE: begin
        done = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign a_o = a_r; assign x_o = x_r; assign y_o = y_r; assign p_o = p_r;
  assign s_o = s_r; assign pc_o = pc_r; assign rd_o = rd_r;
  assign cyc_o = cyc_r; assign bad_o = bad_r;
endmodule

// ===== src/mos6502_instruction_execute_top.sv =====
// Top level of the 6502 instruction executor: stream ports and result register.
// Depends on m65x_pkg, m65x_seq, m65x_mem and the assertion macro header.
`timescale 1ns / 1ps
// One item at a time. Every byte access goes through the single-port data
// memory with its registered read, so indirect pointers, read-modify-write,
// stack pushes and pops and the BRK vector each add memory steps. The
// result waits in an output register; the next item is accepted once that
// register has been taken.
// The memory has no reset; a read of a never-written byte returns garbage.
`include "mos6502_instruction_execute_top_macros.svh"
module mos6502_instruction_execute_top
  import m65x_pkg::*;
#(
  parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // opcode, operand_lo, operand_hi, write_data
  input  logic [1:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // acc, x, y, status, sp, pc, read_data, cycle_count, pad
  output logic        out_tuser   // bad_opcode
);
  mem_req_t req;
  logic [7:0] mem_rdata;
  logic done, busy_r, busy_nxt, ov_r, ov_nxt;
  logic [7:0] a, x, y, p, s, rdv;
  logic [15:0] pc;
  logic [3:0] cyc;
  logic bad;
  logic [67:0] res_r;
  logic bad_r;

  assign in_tready = !busy_r && !ov_r;
  assign out_tvalid = ov_r;

  m65x_seq u_seq (
    .clk(clk), .rst_n(rst_n), .start(in_tvalid && in_tready),
    .kind(in_tuser), .opcode(in_tdata[7:0]), .op_lo(in_tdata[15:8]),
    .op_hi(in_tdata[23:16]), .wdata_in(in_tdata[31:24]), .mem_rdata(mem_rdata),
    .req(req), .done(done), .a_o(a), .x_o(x), .y_o(y), .p_o(p), .s_o(s),
    .pc_o(pc), .rd_o(rdv), .cyc_o(cyc), .bad_o(bad)
  );

  m65x_mem #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_mem (
    .clk(clk), .req(req), .rdata(mem_rdata)
  );

  always_comb begin
    busy_nxt = busy_r;
    ov_nxt = ov_r;
    if (in_tvalid && in_tready) busy_nxt = 1'b1;
    if (done) begin
      busy_nxt = 1'b0;
      ov_nxt = 1'b1;
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r <= ov_nxt;
    end
    if (done) begin
      res_r <= {cyc, rdv, pc, s, p, y, x, a};
      bad_r <= bad;
    end
  end

  assign out_tdata = {4'h0, res_r};
  assign out_tuser = bad_r;

  `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, !(busy_r && in_tready))
  `ASSERT_NEXT(a_done_sets_valid, clk, rst_n, done, out_tvalid)
  `ASSERT_IMPL(a_status_bits, clk, rst_n, p[5] && !p[4])
  `ASSERT_IMPL(a_bad_no_cycles, clk, rst_n, !(out_tvalid && out_tuser) || out_tdata[67:64] == 4'd0)
endmodule
